// File: src/tpte_pkg.sv
package tpte_pkg;

   // sizing
   localparam int FEATURE_WORDS   = 27;
   localparam int MAX_FRAME_BYTES = 2048;
   localparam int RING_BYTES      = 4 * FEATURE_WORDS;
   localparam int RING_AW         = $clog2(RING_BYTES);
   localparam int RCNT_W          = $clog2(RING_BYTES + 1);
   localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);
   localparam int LEN_W           = 12;
   localparam int WIDX_W          = 6;
   localparam int CSR_AW          = 3;
   localparam int CSR_DW          = 32;

   // header byte positions and sizes
   localparam int ETH_TYPE_POS    = 12;
   localparam int IP_VIHL_POS     = 14;
   localparam int IP_PROTO_POS    = 23;
   localparam int ETH_HDR_BYTES   = 14;
   localparam int MIN_HDR_BYTES   = 20;
   localparam int TCP_SPORT_OFS   = 0;
   localparam int TCP_DPORT_OFS   = 2;
   localparam int TCP_DOFF_OFS    = 12;

   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [3:0]  IP_VERSION_4   = 4'd4;
   localparam logic [3:0]  MIN_HDR_WORDS  = 4'd5;
   localparam logic [7:0]  IP_PROTO_TCP   = 8'd6;

   // result status codes
   localparam logic [1:0] STATUS_NONE = 2'd0;
   localparam logic [1:0] STATUS_FAIL = 2'd1;
   localparam logic [1:0] STATUS_WORD = 2'd2;

   // register map, index taken from paddr bit 2
   localparam logic REG_MATCH_PORT    = 1'b0;
   localparam logic REG_MIN_FRAME_LEN = 1'b1;

   localparam logic [15:0]      MATCH_PORT_RESET    = 16'd1507;
   localparam logic [LEN_W-1:0] MIN_FRAME_LEN_RESET = 12'd150;

   typedef struct packed {
      logic [POS_W-1:0] len;
      logic [15:0]      frame_type;
      logic [7:0]       ver_ihl;
      logic [7:0]       proto;
      logic [15:0]      sport;
      logic [15:0]      dport;
      logic [3:0]       offset;
   } hdr_type;

endpackage

// File: src/tpte_ram.sv
module tpte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 108
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/tpte_hdr.sv
module tpte_hdr (
   input  logic              clock,
   input  logic              reset,
   input  logic              byte_valid,
   input  logic [7:0]        frame_byte,
   input  logic              clear,
   output tpte_pkg::hdr_type hdr
);
   import tpte_pkg::*;

   hdr_type           hdr_ff;
   hdr_type           hdr_in;
   logic [3:0]        ihl_eff;
   logic [6:0]        tcp_pos;
   logic [LEN_W-1:0]  pos12;
   logic [LEN_W-1:0]  tcp12;

   always_comb begin
      hdr_in  = hdr_ff;
      pos12   = LEN_W'(hdr_ff.len);
      // ihl written by this byte already moves the tcp header
      ihl_eff = (pos12 == LEN_W'(IP_VIHL_POS)) ? frame_byte[3:0] : hdr_ff.ver_ihl[3:0];
      tcp_pos = 7'(ETH_HDR_BYTES) + {1'b0, ihl_eff, 2'b00};
      tcp12   = LEN_W'(tcp_pos);
      if (clear) begin
         hdr_in = '0;
      end else if (byte_valid && hdr_ff.len < POS_W'(MAX_FRAME_BYTES)) begin
         hdr_in.len = hdr_ff.len + 1'b1;
         if (pos12 == LEN_W'(ETH_TYPE_POS)) hdr_in.frame_type[15:8] = frame_byte;
         if (pos12 == LEN_W'(ETH_TYPE_POS + 1)) hdr_in.frame_type[7:0] = frame_byte;
         if (pos12 == LEN_W'(IP_VIHL_POS)) hdr_in.ver_ihl = frame_byte;
         if (pos12 == LEN_W'(IP_PROTO_POS)) hdr_in.proto = frame_byte;
         if (pos12 == tcp12 + LEN_W'(TCP_SPORT_OFS)) hdr_in.sport[15:8] = frame_byte;
         if (pos12 == tcp12 + LEN_W'(TCP_SPORT_OFS + 1)) hdr_in.sport[7:0] = frame_byte;
         if (pos12 == tcp12 + LEN_W'(TCP_DPORT_OFS)) hdr_in.dport[15:8] = frame_byte;
         if (pos12 == tcp12 + LEN_W'(TCP_DPORT_OFS + 1)) hdr_in.dport[7:0] = frame_byte;
         if (pos12 == tcp12 + LEN_W'(TCP_DOFF_OFS)) hdr_in.offset = frame_byte[7:4];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff <= '0;
      end else begin
         hdr_ff <= hdr_in;
      end
   end

   assign hdr = hdr_ff;

endmodule

// File: src/tpte_emit.sv
module tpte_emit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          byte_valid,
   input  logic                          last_byte,
   input  tpte_pkg::hdr_type             hdr,
   input  logic [15:0]                   match_port,
   input  logic [tpte_pkg::LEN_W-1:0]    min_frame_len,
   input  logic [tpte_pkg::RING_AW-1:0]  ring_ptr,
   output logic                          rd_en,
   output logic [tpte_pkg::RING_AW-1:0]  rd_addr,
   input  logic [7:0]                    rd_data,
   output logic                          hdr_clear,
   output logic                          busy,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [tpte_pkg::WIDX_W-1:0]   rsp_word_index,
   output logic [31:0]                   rsp_feature_word,
   output logic                          rsp_last
);
   import tpte_pkg::*;

   typedef enum logic [1:0] {ST_RUN, ST_JUDGE, ST_DRAIN} state_type;

   localparam logic [WIDX_W-1:0] LAST_WIDX = WIDX_W'(FEATURE_WORDS - 1);

   state_type          state_ff, state_in;
   logic [RING_AW-1:0] rd_addr_ff, rd_addr_in;
   logic [RCNT_W-1:0]  rd_cnt_ff, rd_cnt_in;
   logic               rd_pend_ff, rd_pend_in;
   logic [31:0]        acc_ff, acc_in;
   logic [2:0]         acc_n_ff, acc_n_in;
   logic [WIDX_W-1:0]  widx_ff, widx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [WIDX_W-1:0]  rsp_widx_ff, rsp_widx_in;
   logic [31:0]        rsp_word_ff, rsp_word_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               slot_free;
   logic               issue;
   logic               load_word;
   logic [5:0]         ip_hlen;
   logic [5:0]         tcp_hdr_len;
   logic [7:0]         tcp_end;
   logic [LEN_W-1:0]   len12;
   logic               cand;
   logic               fail;

   // frame verdict from the captured header
   always_comb begin
      len12       = LEN_W'(hdr.len);
      ip_hlen     = {hdr.ver_ihl[3:0], 2'b00};
      tcp_hdr_len = {hdr.offset, 2'b00};
      tcp_end     = 8'(ETH_HDR_BYTES) + 8'(ip_hlen) + 8'(tcp_hdr_len);
      cand = (hdr.frame_type == ETHERTYPE_IPV4) &&
             (hdr.ver_ihl[7:4] == IP_VERSION_4) &&
             (hdr.ver_ihl[3:0] >= MIN_HDR_WORDS) &&
             (hdr.proto == IP_PROTO_TCP) &&
             (len12 >= LEN_W'(ETH_HDR_BYTES) + LEN_W'(ip_hlen) + LEN_W'(MIN_HDR_BYTES)) &&
             ((hdr.sport == match_port) || (hdr.dport == match_port));
      fail = (hdr.offset < MIN_HDR_WORDS) ||
             (len12 <= LEN_W'(tcp_end)) ||
             (len12 < min_frame_len) ||
             (len12 < LEN_W'(tcp_end) + LEN_W'(RING_BYTES));
   end

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign issue     = (state_ff == ST_DRAIN) && (rd_cnt_ff < RCNT_W'(RING_BYTES)) &&
                      ((acc_n_ff + 3'(rd_pend_ff)) < 3'd4);
   assign load_word = (state_ff == ST_DRAIN) && (acc_n_ff == 3'd4) && slot_free;

   always_comb begin
      state_in      = state_ff;
      rd_addr_in    = rd_addr_ff;
      rd_cnt_in     = rd_cnt_ff;
      acc_in        = acc_ff;
      acc_n_in      = acc_n_ff;
      widx_in       = widx_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_widx_in   = rsp_widx_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_last_in   = rsp_last_ff;
      hdr_clear     = 1'b0;

      if (slot_free) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_RUN: begin
            if (byte_valid && last_byte) begin
               state_in = ST_JUDGE;
            end
         end
         ST_JUDGE: begin
            if (cand && !fail) begin
               state_in   = ST_DRAIN;
               hdr_clear  = 1'b1;
               rd_addr_in = ring_ptr;
               rd_cnt_in  = '0;
               acc_n_in   = '0;
               widx_in    = '0;
            end else if (slot_free) begin
               state_in      = ST_RUN;
               hdr_clear     = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_status_in = cand ? STATUS_FAIL : STATUS_NONE;
               rsp_widx_in   = '0;
               rsp_word_in   = '0;
               rsp_last_in   = 1'b1;
            end
         end
         ST_DRAIN: begin
            if (load_word) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_WORD;
               rsp_widx_in   = widx_ff;
               rsp_word_in   = acc_ff;
               rsp_last_in   = (widx_ff == LAST_WIDX);
               acc_n_in      = '0;
               widx_in       = widx_ff + 1'b1;
               if (widx_ff == LAST_WIDX) begin
                  state_in = ST_RUN;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase

      // oldest byte first, wrapping around the ring
      if (issue) begin
         rd_addr_in = (rd_addr_ff == RING_AW'(RING_BYTES - 1)) ? '0 : rd_addr_ff + 1'b1;
         rd_cnt_in  = rd_cnt_ff + 1'b1;
      end
      rd_pend_in = issue;
      if (rd_pend_ff) begin
         acc_in   = {acc_ff[23:0], rd_data};
         acc_n_in = acc_n_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         rd_cnt_ff    <= '0;
         rd_pend_ff   <= 1'b0;
         acc_n_ff     <= '0;
         widx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_cnt_ff    <= rd_cnt_in;
         rd_pend_ff   <= rd_pend_in;
         acc_n_ff     <= acc_n_in;
         widx_ff      <= widx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_addr_ff    <= rd_addr_in;
      acc_ff        <= acc_in;
      rsp_status_ff <= rsp_status_in;
      rsp_widx_ff   <= rsp_widx_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rd_en            = issue;
   assign rd_addr          = rd_addr_ff;
   assign busy             = (state_ff != ST_RUN);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_word_index   = rsp_widx_ff;
   assign rsp_feature_word = rsp_word_ff;
   assign rsp_last         = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_acc_bound: assert property (@(posedge clock) disable iff (reset)
      acc_n_ff <= 3'd4)
      else $error("word assembler holds more than four bytes");

   a_pend_in_drain: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> state_ff == ST_DRAIN)
      else $error("ring read data arrived outside of drain");

   a_read_bound: assert property (@(posedge clock) disable iff (reset)
      rd_cnt_ff <= RCNT_W'(RING_BYTES))
      else $error("more ring reads than trailer bytes");

   a_drain_ends: assert property (@(posedge clock) disable iff (reset)
      (load_word && widx_ff == LAST_WIDX) |=> state_ff == ST_RUN)
      else $error("drain did not end after the final word");
`endif

endmodule

// File: src/tcp_port_trailer_extractor.sv
// Byte-wide frame parser: one frame byte per transaction with a last-byte flag.
// Within a frame a byte is taken every cycle. After the final byte the block
// holds req_stall while it judges the header (ethertype, IPv4 version/IHL/
// protocol, TCP ports and data offset against match_port and min_frame_len).
// A non-candidate or a failed candidate yields one status transaction and
// input resumes as soon as the output register has room. A good candidate
// yields FEATURE_WORDS big-endian words built from the last 4*FEATURE_WORDS
// bytes; these are read back from the trailer ram, four reads and one output
// load per word, with req_stall held high throughout and output backpressure
// able to hold the drain. The ring needs no clearing pass after reset.
module tcp_port_trailer_extractor (
   input  logic                          clock,
   input  logic                          reset,
   // input transactions
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_frame_byte,
   input  logic                          req_last_byte,
   // result transactions
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [5:0]                    rsp_word_index,
   output logic [31:0]                   rsp_feature_word,
   output logic                          rsp_last,
   // register port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [tpte_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [tpte_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [tpte_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import tpte_pkg::*;

   logic               req_acc;
   logic               csr_wr;
   logic [15:0]        match_port_ff, match_port_in;
   logic [LEN_W-1:0]   min_len_ff, min_len_in;
   logic [RING_AW-1:0] ring_ptr_ff, ring_ptr_in;
   hdr_type            hdr;
   logic               hdr_clear;
   logic               rd_en;
   logic [RING_AW-1:0] rd_addr;
   logic [7:0]         rd_data;
   logic               busy;

   // a byte moves when offered and not held back
   assign req_acc   = req_valid && !req_stall;
   assign req_stall = busy;

   // register port, zero wait states
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      match_port_in = match_port_ff;
      min_len_in    = min_len_ff;
      if (csr_wr) begin
         case (csr_paddr[2])
            REG_MATCH_PORT:    match_port_in = csr_pwdata[15:0];
            REG_MIN_FRAME_LEN: min_len_in    = csr_pwdata[LEN_W-1:0];
            default:           match_port_in = match_port_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_MATCH_PORT:    csr_prdata = CSR_DW'(match_port_ff);
         REG_MIN_FRAME_LEN: csr_prdata = CSR_DW'(min_len_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // ring write pointer runs across frames, every byte lands in the ring
   always_comb begin
      ring_ptr_in = ring_ptr_ff;
      if (req_acc) begin
         ring_ptr_in = (ring_ptr_ff == RING_AW'(RING_BYTES - 1)) ? '0 : ring_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_port_ff <= MATCH_PORT_RESET;
         min_len_ff    <= MIN_FRAME_LEN_RESET;
         ring_ptr_ff   <= '0;
      end else begin
         match_port_ff <= match_port_in;
         min_len_ff    <= min_len_in;
         ring_ptr_ff   <= ring_ptr_in;
      end
   end

   // trailer ring: written while bytes stream, read only during a drain
   tpte_ram #(
      .WIDTH(8),
      .DEPTH(RING_BYTES)
   ) u_ring (
      .clock   (clock),
      .wr_en   (req_acc),
      .wr_addr (ring_ptr_ff),
      .wr_data (req_frame_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // header field capture and position count
   tpte_hdr u_hdr (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_acc),
      .frame_byte (req_frame_byte),
      .clear      (hdr_clear),
      .hdr        (hdr)
   );

   // verdict, ring drain and output register
   tpte_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .byte_valid       (req_acc),
      .last_byte        (req_last_byte),
      .hdr              (hdr),
      .match_port       (match_port_ff),
      .min_frame_len    (min_len_ff),
      .ring_ptr         (ring_ptr_ff),
      .rd_en            (rd_en),
      .rd_addr          (rd_addr),
      .rd_data          (rd_data),
      .hdr_clear        (hdr_clear),
      .busy             (busy),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_word_index   (rsp_word_index),
      .rsp_feature_word (rsp_feature_word),
      .rsp_last         (rsp_last)
   );

endmodule
